>>> sv/sscan_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sscan_pkg
// Shared types, codes and the segment decode for the four-digit scanner.
// ----------------------------------------------------------------------------
package sscan_pkg;

    // request kinds on the input stream
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_VOLTAGE = 2'd1;
    localparam logic [1:0] KIND_CURRENT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VOLTAGE_SHIFT = 2'd0;
    localparam logic [1:0] CFG_CURRENT_SHIFT = 2'd1;
    localparam logic [1:0] CFG_SEG_POLARITY  = 2'd2;
    localparam logic [1:0] CFG_EN_POLARITY   = 2'd3;

    localparam logic [3:0] VOLTAGE_SHIFT_RST = 4'd8;
    localparam logic [3:0] CURRENT_SHIFT_RST = 4'd12;

    // scan positions, digit 4 first
    localparam logic [1:0] SCAN_VOLT_ONES  = 2'd0;
    localparam logic [1:0] SCAN_VOLT_TENS  = 2'd1;
    localparam logic [1:0] SCAN_CURR_WHOLE = 2'd2;
    localparam logic [1:0] SCAN_CURR_TENTH = 2'd3;

    localparam logic [7:0] MINUS_CODE = 8'd45;
    localparam logic [11:0] FRAC_MASK = 12'hFFF;

    typedef struct packed {
        logic [3:0] volt_ones;
        logic [3:0] volt_tens;
        logic [7:0] curr_whole;
        logic [7:0] curr_tenths;
    } t_digits;

    typedef struct packed {
        logic       dp;
        logic [3:0] en;
        logic [6:0] seg;
    } t_pins;

    // segments A..G at bits 0..6
    function automatic logic [6:0] seg_decode(input logic [7:0] code);
        logic [6:0] seg;
        case (code)
            8'd0:       seg = 7'h3F;
            8'd1:       seg = 7'h06;
            8'd2:       seg = 7'h5B;
            8'd3:       seg = 7'h4F;
            8'd4:       seg = 7'h66;
            8'd5:       seg = 7'h6D;
            8'd6:       seg = 7'h7D;
            8'd7:       seg = 7'h07;
            8'd8:       seg = 7'h7F;
            8'd9:       seg = 7'h6F;
            MINUS_CODE: seg = 7'h20;
            default:    seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

>>> sv/four_digit_seven_segment_scanner_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted request is held in the input register, and its result is then
//   formed into the result register.
// Throughput: one request per cycle; ready only drops when the input register holds a
//   request and the result register is full and not taken.
// Reset (synchronous, active low) clears both stages, the stored digits, the scan
//   position (digit 4 first), the pin levels and sets the configuration defaults.
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scanner_top
// Four-digit multiplexed seven-segment scanner with stream ports.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scanner_top
    import sscan_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] reading
    input  wire logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [6:0] segments, [10:7] digit_enables,
                                          // [11] decimal_point, [15:12] zero
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);

    logic [3:0]  r_voltage_shift;
    logic [3:0]  r_current_shift;
    logic        r_seg_high;
    logic        r_en_high;

    logic        r_s1_valid;
    logic [1:0]  r_s1_kind;
    logic [15:0] r_s1_reading;

    logic [3:0]  r_volt_ones;
    logic [3:0]  r_volt_tens;
    logic [7:0]  r_curr_whole;
    logic [7:0]  r_curr_tenths;
    logic [1:0]  r_scan_pos;
    t_pins       r_pins;

    logic        r_m_valid;
    logic [11:0] r_m_data;

    logic        out_ready;
    logic        s2_fire;
    t_digits     conv_digits;
    t_digits     held_digits;
    t_pins       disp_pins;
    t_pins       n_pins;
    logic [11:0] n_m_data;

    assign o_cfg_ready = 1'b1;
    assign out_ready   = !r_m_valid || i_m_tready;
    assign o_s_tready  = !r_s1_valid || out_ready;
    assign s2_fire     = r_s1_valid && out_ready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'd0, r_m_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage_shift <= VOLTAGE_SHIFT_RST;
            r_current_shift <= CURRENT_SHIFT_RST;
            r_seg_high      <= 1'b1;
            r_en_high       <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOLTAGE_SHIFT: r_voltage_shift <= i_cfg_data;
                CFG_CURRENT_SHIFT: r_current_shift <= i_cfg_data;
                CFG_SEG_POLARITY:  r_seg_high      <= i_cfg_data[0];
                CFG_EN_POLARITY:   r_en_high       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_kind    <= i_s_tuser;
            r_s1_reading <= i_s_tdata;
        end
    end

    sscan_conv u_conv (
        .i_reading       (r_s1_reading),
        .i_voltage_shift (r_voltage_shift),
        .i_current_shift (r_current_shift),
        .o_digits        (conv_digits)
    );

    always_comb begin
        held_digits.volt_ones   = r_volt_ones;
        held_digits.volt_tens   = r_volt_tens;
        held_digits.curr_whole  = r_curr_whole;
        held_digits.curr_tenths = r_curr_tenths;
    end

    sscan_disp u_disp (
        .i_digits   (held_digits),
        .i_scan_pos (r_scan_pos),
        .o_pins     (disp_pins)
    );

    // polarity is applied as the result is formed
    always_comb begin
        n_pins = (r_s1_kind == KIND_TICK) ? disp_pins : r_pins;
        n_m_data[6:0]  = r_seg_high ? n_pins.seg : ~n_pins.seg;
        n_m_data[10:7] = r_en_high ? n_pins.en : ~n_pins.en;
        n_m_data[11]   = n_pins.dp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_ones   <= '0;
            r_volt_tens   <= '0;
            r_curr_whole  <= '0;
            r_curr_tenths <= '0;
            r_scan_pos    <= SCAN_VOLT_ONES;
            r_pins        <= '0;
        end else if (s2_fire) begin
            case (r_s1_kind)
                KIND_TICK: begin
                    r_pins     <= disp_pins;
                    r_scan_pos <= r_scan_pos + 2'd1;
                end
                KIND_VOLTAGE: begin
                    r_volt_ones <= conv_digits.volt_ones;
                    r_volt_tens <= conv_digits.volt_tens;
                end
                KIND_CURRENT: begin
                    r_curr_whole  <= conv_digits.curr_whole;
                    r_curr_tenths <= conv_digits.curr_tenths;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s2_fire) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_m_data <= n_m_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/sscan_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sscan_conv
// Turns a raw voltage or current reading into the stored display values.
// ----------------------------------------------------------------------------
module sscan_conv
    import sscan_pkg::*;
(
    input  wire logic [15:0] i_reading,
    input  wire logic [3:0]  i_voltage_shift,
    input  wire logic [3:0]  i_current_shift,
    output t_digits          o_digits
);

    logic [7:0]  volt_n;
    logic [15:0] div_prod;
    logic [4:0]  volt_q;
    logic [7:0]  ones_full;
    logic [4:0]  tens_full;
    logic [15:0] frac_x10;
    logic [15:0] frac_sh;
    logic [15:0] whole_sh;

    always_comb begin
        volt_n   = 8'(i_reading >> i_voltage_shift);
        // n / 10 == (n * 205) >> 11 for all 8-bit n
        div_prod = 16'(volt_n) * 16'd205;
        volt_q   = div_prod[15:11];
        ones_full = volt_n - 8'({volt_q, 3'b000}) - 8'({volt_q, 1'b0});
        if (volt_q >= 5'd20) begin
            tens_full = volt_q - 5'd20;
        end else if (volt_q >= 5'd10) begin
            tens_full = volt_q - 5'd10;
        end else begin
            tens_full = volt_q;
        end

        // (reading & 0xFFF) * 10 fits in 16 bits
        frac_x10 = {1'b0, i_reading[11:0] & FRAC_MASK, 3'b000}
                 + {3'b000, i_reading[11:0] & FRAC_MASK, 1'b0};
        frac_sh  = frac_x10 >> i_current_shift;
        whole_sh = i_reading >> i_current_shift;

        o_digits.volt_ones   = ones_full[3:0];
        o_digits.volt_tens   = tens_full[3:0];
        o_digits.curr_whole  = whole_sh[7:0];
        o_digits.curr_tenths = frac_sh[7:0];
    end

endmodule
`default_nettype wire

>>> sv/sscan_disp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sscan_disp
// Selects the digit for the current scan position and builds its pin levels.
// ----------------------------------------------------------------------------
module sscan_disp
    import sscan_pkg::*;
(
    input  wire t_digits     i_digits,
    input  wire logic [1:0]  i_scan_pos,
    output t_pins            o_pins
);

    logic [7:0] code;

    always_comb begin
        o_pins.dp = 1'b1;
        case (i_scan_pos)
            SCAN_VOLT_ONES: begin
                code      = {4'd0, i_digits.volt_ones};
                o_pins.en = 4'b1000;
            end
            SCAN_VOLT_TENS: begin
                code      = {4'd0, i_digits.volt_tens};
                o_pins.en = 4'b0100;
            end
            SCAN_CURR_WHOLE: begin
                code      = i_digits.curr_whole;
                o_pins.en = 4'b0010;
                o_pins.dp = 1'b0;
            end
            default: begin
                code      = i_digits.curr_tenths;
                o_pins.en = 4'b0001;
            end
        endcase
        o_pins.seg = seg_decode(code);
    end

endmodule
`default_nettype wire

>>> sv/sscan_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sscan_check
// Port-level checks on the scanner's result stream.
// ----------------------------------------------------------------------------
module sscan_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [15:0] o_m_tdata
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // nothing comes out in the cycle after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    // at most one digit enabled, in either polarity, and the padding bits are zero
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($onehot0(o_m_tdata[10:7]) || $countones(o_m_tdata[10:7]) >= 3)
                       && o_m_tdata[15:12] == 4'd0)
        else $error("bad digit enables or padding");

    // decimal point is off on digit 2 and while no digit is shown
    a_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[10:7] == 4'b0010 || o_m_tdata[10:7] == 4'b1101
                       || o_m_tdata[10:7] == 4'b0000 || o_m_tdata[10:7] == 4'b1111)
        |-> !o_m_tdata[11])
        else $error("decimal point lit on digit 2 or blank");

endmodule

bind four_digit_seven_segment_scanner_top sscan_check u_sscan_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the four-digit seven-segment scanner. Ticks, voltage
// and current readings and the unused kind are sent through the input
// stream, under several register settings and idle patterns on both sides.
// Every result is compared field by field with a prediction of the pins.
// ----------------------------------------------------------------------------
module testbench;
    import sscan_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 240;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [6:0] SEG_F_ONLY  = 7'h20;

    // predicts the pin levels shown after each request
    class display_scoreboard;
        logic [3:0] volt_shift;
        logic [3:0] curr_shift;
        logic       seg_high;
        logic       en_high;
        logic [7:0] volt_ones;
        logic [7:0] volt_tens;
        logic [7:0] curr_whole;
        logic [7:0] curr_tenths;
        logic [1:0] scan_pos;
        t_pins      held;
        t_pins      expected_pins[$];
        int         errors;
        logic [6:0] numeral_segs[10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                         7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

        function new();
            volt_shift  = VOLTAGE_SHIFT_RST;
            curr_shift  = CURRENT_SHIFT_RST;
            seg_high    = 1'b1;
            en_high     = 1'b1;
            volt_ones   = '0;
            volt_tens   = '0;
            curr_whole  = '0;
            curr_tenths = '0;
            scan_pos    = SCAN_VOLT_ONES;
            held        = '0;
            errors      = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [3:0] data);
            case (idx)
                CFG_VOLTAGE_SHIFT: volt_shift = data;
                CFG_CURRENT_SHIFT: curr_shift = data;
                CFG_SEG_POLARITY:  seg_high   = data[0];
                CFG_EN_POLARITY:   en_high    = data[0];
                default: ;
            endcase
        endfunction

        function logic [6:0] seg_pattern(logic [7:0] code);
            if (code < 8'd10) return numeral_segs[code];
            if (code == MINUS_CODE) return SEG_F_ONLY;
            return 7'h00;
        endfunction

        function void note_request(logic [1:0] kind, logic [15:0] reading);
            logic [7:0]  volts;
            logic [15:0] frac;
            logic [7:0]  code;
            t_pins       shown;
            case (kind)
                KIND_VOLTAGE: begin
                    volts     = 8'(reading >> volt_shift);
                    volt_ones = volts % 8'd10;
                    volt_tens = (volts / 8'd10) % 8'd10;
                end
                KIND_CURRENT: begin
                    // fraction product fits in 16 bits before the shift
                    frac        = 16'(32'(reading & {4'h0, FRAC_MASK}) * 32'd10);
                    curr_whole  = 8'(reading >> curr_shift);
                    curr_tenths = 8'(frac >> curr_shift);
                end
                KIND_TICK: begin
                    held.dp = 1'b1;
                    case (scan_pos)
                        SCAN_VOLT_ONES: begin
                            code    = volt_ones;
                            held.en = 4'b1000;
                        end
                        SCAN_VOLT_TENS: begin
                            code    = volt_tens;
                            held.en = 4'b0100;
                        end
                        SCAN_CURR_WHOLE: begin
                            code    = curr_whole;
                            held.en = 4'b0010;
                            held.dp = 1'b0;
                        end
                        default: begin
                            code    = curr_tenths;
                            held.en = 4'b0001;
                        end
                    endcase
                    held.seg = seg_pattern(code);
                    scan_pos = scan_pos + 2'd1;
                end
                default: ;
            endcase
            shown     = held;
            shown.seg = seg_high ? held.seg : ~held.seg;
            shown.en  = en_high ? held.en : ~held.en;
            expected_pins.push_back(shown);
        endfunction

        function void check_result(logic [15:0] tdata);
            t_pins want;
            t_pins got;
            if (expected_pins.size() == 0) begin
                $error("unexpected result %h", tdata);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            got  = tdata[11:0];
            if (got.seg !== want.seg) begin
                $error("segments: expected %h, got %h", want.seg, got.seg);
                errors++;
            end
            if (got.en !== want.en) begin
                $error("digit_enables: expected %h, got %h", want.en, got.en);
                errors++;
            end
            if (got.dp !== want.dp) begin
                $error("decimal_point: expected %b, got %b", want.dp, got.dp);
                errors++;
            end
            if (tdata[15:12] !== 4'h0) begin
                $error("padding: expected 0, got %h", tdata[15:12]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [3:0]  i_cfg_data;

    display_scoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  idle_on;
    int  cycle_count;

    four_digit_seven_segment_scanner_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= !(idle_on && $urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.note_request(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // entered and left just after a falling edge
    task automatic send_request(input logic [1:0] kind, input logic [15:0] reading);
        while (idle_on && $urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= reading;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [3:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [3:0] vs, input logic [3:0] cs,
                                  input logic seg_pol, input logic en_pol);
        write_register(CFG_VOLTAGE_SHIFT, vs);
        write_register(CFG_CURRENT_SHIFT, cs);
        write_register(CFG_SEG_POLARITY, {3'b000, seg_pol});
        write_register(CFG_EN_POLARITY, {3'b000, en_pol});
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_request(KIND_TICK, 16'($urandom()));
    endtask

    // mostly values that land on numerals, plus the minus code and extremes
    function automatic logic [15:0] pick_reading(logic [1:0] kind);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return 16'($urandom());
        if (sel == 3) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        if (kind == KIND_CURRENT && sel == 4) return 16'(32'd45 << sb.curr_shift);
        if (kind == KIND_CURRENT) return 16'($urandom_range(0, 9) << sb.curr_shift)
                                      | 16'($urandom_range(0, 4095));
        return 16'($urandom_range(0, 255) << sb.volt_shift);
    endfunction

    initial begin
        logic [3:0] vs_tab[PHASES]  = '{4'd8, 4'd0, 4'd15, 4'd4, 4'd0, 4'd15};
        logic [3:0] cs_tab[PHASES]  = '{4'd12, 4'd0, 4'd15, 4'd9, 4'd0, 4'd0};
        logic       seg_tab[PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        logic       en_tab[PHASES]  = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        int         roll;
        logic [1:0] kind;

        sb          = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = KIND_TICK;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_VOLTAGE_SHIFT;
        i_cfg_data  = '0;
        idle_on     = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        cycle_count = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: a full scan of reset digits, then extremes under defaults
        send_ticks(4);
        send_request(KIND_VOLTAGE, 16'hFFFF);
        send_request(KIND_CURRENT, 16'hFFFF);
        send_request(KIND_UNUSED, 16'hFFFF);
        send_ticks(4);
        wait_results_drained();

        // inverted polarity; current of 9 at shift 1 gives a minus in tenths
        apply_settings(4'd0, 4'd1, 1'b0, 1'b0);
        send_request(KIND_VOLTAGE, 16'd99);
        send_request(KIND_CURRENT, 16'd9);
        send_ticks(4);
        // whole part of 45 shows a minus on digit 2, tenths go blank
        send_request(KIND_CURRENT, 16'd90);
        send_request(KIND_VOLTAGE, 16'h0000);
        send_request(KIND_UNUSED, 16'h0000);
        send_ticks(4);
        wait_results_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 4) begin
                apply_settings(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                apply_settings(vs_tab[ph], cs_tab[ph], seg_tab[ph], en_tab[ph]);
            end
            if (ph < 2) begin
                tx_idle_pct = 13;
                rx_idle_pct = 70;
            end else if (ph < 4) begin
                tx_idle_pct = 70;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_on = (n % 64) < 48;
                if (n == PHASE_ITEMS / 2) wait_results_drained();
                roll = $urandom_range(0, 99);
                if (roll < 50) kind = KIND_TICK;
                else if (roll < 70) kind = KIND_VOLTAGE;
                else if (roll < 92) kind = KIND_CURRENT;
                else kind = KIND_UNUSED;
                send_request(kind, pick_reading(kind));
            end
            idle_on = 1'b0;
            wait_results_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/sscan_pkg.sv
sv/sscan_conv.sv
sv/sscan_disp.sv
sv/four_digit_seven_segment_scanner_top.sv
sv/sscan_check.sv
bench/testbench.sv
